@@ rtl/trimmed_mean_sample_averager_top_assert.svh @@
// assertion macros for the trimmed mean sample averager
`ifndef TRIMMED_MEAN_SAMPLE_AVERAGER_TOP_ASSERT_SVH
`define TRIMMED_MEAN_SAMPLE_AVERAGER_TOP_ASSERT_SVH
`ifndef SYNTH
`define TMSA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tmsa assertion failed");
`define TMSA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tmsa reset assertion failed");
`else
`define TMSA_ASSERT(lbl, prop)
`define TMSA_ASSERT_RST(lbl, prop)
`endif
`endif

@@ rtl/tmsa_pkg.sv @@
// shared constants and types for the trimmed mean sample averager
package tmsa_pkg;

  localparam int SAMPLE_IN_W = 12;
  localparam int AVG_W       = 12;
  localparam logic [AVG_W-1:0] AVG_MAX = 12'hfff;

  localparam int BURST_LENGTH_DEF  = 20;
  localparam int DISCARD_COUNT_DEF = 2;
  localparam int AVERAGE_SHIFT_DEF = 4;
  localparam int SAMPLE_WIDTH_DEF  = 12;

  typedef struct packed {
    logic [SAMPLE_IN_W-1:0] sample;
    logic                   restart;
  } tmsa_item_t;

  typedef struct packed {
    logic             last;
    logic [AVG_W-1:0] average;
  } tmsa_result_t;

endpackage

@@ rtl/tmsa_if.sv @@
// stream interfaces for the sample input and the average output
interface tmsa_in_if import tmsa_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_IN_W-1:0] sample;
  logic                   restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface tmsa_out_if import tmsa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [AVG_W-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

@@ rtl/trimmed_mean_sample_averager_top.sv @@
// the last sample waits in item_r; its average is then registered in avg_r
// one sample per cycle unless a burst end stalls; sum, max, min are combinational
// a burst of BURST_LENGTH samples gives one average
// a stalled output holds the pending stage only when it holds a burst end
// reset (rst_n low, synchronous) empties both registers and starts a new burst
module trimmed_mean_sample_averager_top import tmsa_pkg::*; #(
  parameter int BURST_LENGTH  = BURST_LENGTH_DEF,
  parameter int DISCARD_COUNT = DISCARD_COUNT_DEF,
  parameter int AVERAGE_SHIFT = AVERAGE_SHIFT_DEF,
  parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tmsa_in_if.sink    in_chan,
  tmsa_out_if.source out_chan
);

`include "trimmed_mean_sample_averager_top_assert.svh"

  tmsa_item_t       item_r, item_nxt;
  logic             in_valid_r, in_valid_nxt;
  logic [AVG_W-1:0] avg_r, avg_nxt;
  logic             out_valid_r, out_valid_nxt;
  tmsa_result_t     result;
  logic             step;
  logic             in_fire;

  tmsa_burst #(
    .BURST_LENGTH (BURST_LENGTH),
    .DISCARD_COUNT(DISCARD_COUNT),
    .AVERAGE_SHIFT(AVERAGE_SHIFT),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_burst (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .result(result)
  );

  // a burst end waits only if the output register is occupied and out ready is low
  assign step    = in_valid_r && (!result.last || !out_valid_r || out_chan.ready);
  assign in_fire = in_chan.valid && in_chan.ready;

  assign in_chan.ready    = !in_valid_r || step;
  assign out_chan.valid   = out_valid_r;
  assign out_chan.average = avg_r;

  always_comb begin
    item_nxt      = item_r;
    in_valid_nxt  = in_valid_r;
    avg_nxt       = avg_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_chan.ready) out_valid_nxt = 1'b0;
    if (step) begin
      in_valid_nxt = 1'b0;
      if (result.last) begin
        avg_nxt       = result.average;
        out_valid_nxt = 1'b1;
      end
    end
    if (in_fire) begin
      item_nxt.sample  = in_chan.sample;
      item_nxt.restart = in_chan.restart;
      in_valid_nxt     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    avg_r  <= avg_nxt;
  end

  `TMSA_ASSERT(a_no_overwrite, step && result.last |-> !out_valid_r || out_chan.ready)
  `TMSA_ASSERT(a_stall_holds, in_valid_r && !step |=> in_valid_r && $stable(item_r))
  `TMSA_ASSERT(a_result_only_on_end, !out_valid_r ##1 out_valid_r |-> $past(step && result.last))
  `TMSA_ASSERT_RST(a_reset_empty, !rst_n |=> !in_valid_r && !out_valid_r)

endmodule

@@ rtl/tmsa_burst.sv @@
// burst state: running sum, max and min, and the trimmed average at burst end
module tmsa_burst import tmsa_pkg::*; #(
  parameter int BURST_LENGTH  = BURST_LENGTH_DEF,
  parameter int DISCARD_COUNT = DISCARD_COUNT_DEF,
  parameter int AVERAGE_SHIFT = AVERAGE_SHIFT_DEF,
  parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  tmsa_item_t   item,
  output tmsa_result_t result
);

  localparam int IDX_W  = $clog2(BURST_LENGTH);
  localparam int KEEP_W = (SAMPLE_WIDTH < SAMPLE_IN_W) ? SAMPLE_WIDTH : SAMPLE_IN_W;
  localparam int SUM_W  = SAMPLE_WIDTH + $clog2(BURST_LENGTH + 1);
  localparam int CW     = (SUM_W > AVG_W) ? SUM_W : AVG_W;

  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [SAMPLE_WIDTH-1:0] max_r, max_nxt;
  logic [SAMPLE_WIDTH-1:0] min_r, min_nxt;

  logic [SAMPLE_WIDTH-1:0] s;
  logic [IDX_W-1:0]        idx_eff;
  logic                    kept;
  logic                    last;
  logic [SUM_W-1:0]        base_sum, new_sum;
  logic [SAMPLE_WIDTH-1:0] base_max, base_min, new_max, new_min;
  logic [SAMPLE_WIDTH:0]   trim;
  logic [SUM_W-1:0]        trim_ext, total;
  logic [CW-1:0]           avg_full;

  always_comb begin
    s = '0;
    s[KEEP_W-1:0] = item.sample[KEEP_W-1:0];

    // restart drops the partial burst before this sample is handled
    idx_eff  = item.restart ? '0 : idx_r;
    base_sum = item.restart ? '0 : sum_r;
    base_max = item.restart ? '0 : max_r;
    base_min = item.restart ? '1 : min_r;

    kept = 32'(idx_eff) >= 32'(DISCARD_COUNT);
    last = idx_eff == IDX_W'(BURST_LENGTH - 1);

    new_sum = base_sum;
    new_max = base_max;
    new_min = base_min;
    if (kept) begin
      new_sum = base_sum + SUM_W'(s);
      if (s > base_max) new_max = s;
      if (s < base_min) new_min = s;
    end

    // clamp at zero when too few samples were kept
    trim     = {1'b0, new_max} + {1'b0, new_min};
    trim_ext = SUM_W'(trim);
    total    = (new_sum > trim_ext) ? (new_sum - trim_ext) : '0;
    avg_full = CW'(total >> AVERAGE_SHIFT);

    result.last    = last;
    result.average = (avg_full > CW'(AVG_MAX)) ? AVG_MAX : avg_full[AVG_W-1:0];

    idx_nxt = idx_r;
    sum_nxt = sum_r;
    max_nxt = max_r;
    min_nxt = min_r;
    if (step) begin
      if (last) begin
        idx_nxt = '0;
        sum_nxt = '0;
        max_nxt = '0;
        min_nxt = '1;
      end else begin
        idx_nxt = idx_eff + IDX_W'(1);
        sum_nxt = new_sum;
        max_nxt = new_max;
        min_nxt = new_min;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      sum_r <= '0;
      max_r <= '0;
      min_r <= '1;
    end else begin
      idx_r <= idx_nxt;
      sum_r <= sum_nxt;
      max_r <= max_nxt;
      min_r <= min_nxt;
    end
  end

endmodule
